[sv/lup_pkg.sv]
// Shared types and constants for the linear interpolation upsampler.
package lup_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int PHASE_W  = 16;

   // Smallest phase step honoured; keeps a frame at eight results or fewer
   localparam logic [PHASE_W-1:0] STEP_MIN   = 16'd8192;
   localparam logic [PHASE_W-1:0] STEP_RESET = 16'd32768;

   // Source frame request
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } req_type;

   // Interpolated output frame
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       run_last;
   } rsp_type;

   // One interpolation interval: start frame and slope to the next frame
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] prev_left;
      logic signed [SAMPLE_W-1:0] prev_right;
      logic signed [DIFF_W-1:0]   diff_left;
      logic signed [DIFF_W-1:0]   diff_right;
   } span_type;

   // Handshake between queue stages
   typedef struct packed {
      logic     valid;
      span_type span;
   } span_push_type;

endpackage

[sv/lup_front.sv]
// Front end: takes source frames, primes on the first one, forms intervals.
module lup_front
   import lup_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_payload,
   input  logic          q_full,
   output span_push_type q_push
);

   logic                       primed_ff, primed_in;
   logic signed [SAMPLE_W-1:0] prev_left_ff, prev_left_in;
   logic signed [SAMPLE_W-1:0] prev_right_ff, prev_right_in;
   logic signed [SAMPLE_W-1:0] cur_left, cur_right;
   logic                       accept;

   // Mono build repeats the left channel
   assign cur_left  = req_payload.left_sample;
   assign cur_right = (CHANNELS >= 2) ? req_payload.right_sample : req_payload.left_sample;

   // The priming frame never needs queue space
   assign req_stall = primed_ff && q_full;
   assign accept    = req_valid && !req_stall;

   // Interval from stored frame to the incoming one
   always_comb begin
      q_push.valid           = accept && primed_ff;
      q_push.span.prev_left  = prev_left_ff;
      q_push.span.prev_right = prev_right_ff;
      q_push.span.diff_left  = DIFF_W'(cur_left) - DIFF_W'(prev_left_ff);
      q_push.span.diff_right = DIFF_W'(cur_right) - DIFF_W'(prev_right_ff);
   end

   always_comb begin
      primed_in     = primed_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      if (accept) begin
         primed_in     = 1'b1;
         prev_left_in  = cur_left;
         prev_right_in = cur_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else begin
         primed_ff <= primed_in;
      end
      prev_left_ff  <= prev_left_in;
      prev_right_ff <= prev_right_in;
   end

endmodule

[sv/lup_queue.sv]
// Two-entry queue of intervals between front and back end.
module lup_queue
   import lup_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  span_push_type q_push,
   output logic          q_full,
   output logic          q_valid,
   output span_type      q_head,
   input  logic          q_pop
);

   localparam int DEPTH = 2;

   span_type   entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign q_full  = (count_ff == 2'(DEPTH));
   assign q_valid = (count_ff != 2'd0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push.valid && !q_full;
   assign do_pop  = q_pop && q_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.span;
      end
   end

endmodule

[sv/lup_back.sv]
// Back end: walks the phase across one interval, one output frame a cycle while the receiver does not stall.
module lup_back
   import lup_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [PHASE_W-1:0] csr_step,
   input  logic               q_valid,
   input  span_type           q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload
);

   span_type           job_ff, job_in;
   logic               job_valid_ff, job_valid_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [PHASE_W-1:0]         step;
   logic [PHASE_W:0]           phase_sum;
   logic                       emit, last;
   logic signed [DIFF_W:0]     phase_s;
   logic signed [2*DIFF_W-1:0] prod_left, prod_right;
   logic signed [DIFF_W:0]     lerp_left, lerp_right;

   // Clamp the step so an interval yields at most eight outputs
   assign step      = (csr_step < STEP_MIN) ? STEP_MIN : csr_step;
   assign phase_sum = {1'b0, phase_ff} + {1'b0, step};
   assign last      = phase_sum[PHASE_W];
   assign emit      = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = q_valid && (!job_valid_ff || (emit && last));

   // prev + floor(diff * phase / 2^16); arithmetic shift gives the floor
   assign phase_s    = $signed({2'b00, phase_ff});
   assign prod_left  = job_ff.diff_left * phase_s;
   assign prod_right = job_ff.diff_right * phase_s;
   assign lerp_left  = (DIFF_W+1)'(job_ff.prev_left) + prod_left[2*DIFF_W-1 -: DIFF_W+1];
   assign lerp_right = (DIFF_W+1)'(job_ff.prev_right) + prod_right[2*DIFF_W-1 -: DIFF_W+1];

   // Interval and phase sequencing
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      phase_in     = phase_ff;
      if (emit) begin
         phase_in = phase_sum[PHASE_W-1:0];
         if (last) begin
            job_valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         job_in       = q_head;
         job_valid_in = 1'b1;
      end
   end

   // Output register; holds while the receiver stalls
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.left_out  = lerp_left[SAMPLE_W-1:0];
         rsp_in.right_out = lerp_right[SAMPLE_W-1:0];
         rsp_in.run_last  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[sv/linear_interp_upsampler_core.sv]
// Streaming stereo linear interpolation upsampler, top level.
//
// Source frames arrive on req_ (valid/stall); interpolated frames leave on
// rsp_ (valid/stall), run_last marking the final output of each source frame.
// csr_wr_en/csr_wr_data write the Q0.16 phase step (source over output rate);
// steps below 8192 act as 8192. Write it only while the block is idle.
// The first frame after reset only primes the stored frame and gives nothing.
// Each later frame gives 1 to 8 outputs, one per cycle while the receiver
// does not stall, from a single shared interpolation unit. When the back
// end is free, an accepted frame passes through the queue entry and the
// job register into the output register, where its first output is shown.
// A two-entry interval queue lets the front end keep taking frames while
// the back end works or the receiver stalls; req_stall rises only once that
// queue is full.
// A stalled output is held in the output register unchanged.
// Reset (synchronous) clears the primed flag, phase and queue and
// returns the step to 32768 (2x).
module linear_interp_upsampler_core
   import lup_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_payload,
   input  logic               csr_wr_en,
   input  logic [PHASE_W-1:0] csr_wr_data
);

   logic [PHASE_W-1:0] step_ff, step_in;
   span_push_type      q_push;
   logic               q_full, q_valid, q_pop;
   span_type           q_head;

   // Phase step register
   assign step_in = csr_wr_en ? csr_wr_data : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   lup_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push)
   );

   lup_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop)
   );

   lup_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_step    (step_ff),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[bench/tb.sv]
// Self-checking testbench for the linear interpolation upsampler core.
module tb
   import lup_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PHASE_ONE   = 65536;
   localparam int          MAX_RUN     = 8;
   localparam int          SETTLE      = 12;
   localparam int          CYCLE_LIMIT = 300000;
   localparam int          REPORT_MAX  = 10;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_payload;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_wr_en;
   logic [PHASE_W-1:0] csr_wr_data;

   // Predictor state, mirrors the block's stored frame, phase and step
   logic signed [SAMPLE_W-1:0] prev_left_q;
   logic signed [SAMPLE_W-1:0] prev_right_q;
   int unsigned                phase_q;
   logic                       primed_q;
   logic [PHASE_W-1:0]         step_q;

   rsp_type expected_frames[$];
   req_type last_frame;

   int mismatches;
   int results_checked;
   int frames_sent;
   int steps_written;
   int cycle_count;

   // Sender burst shape and receiver stall density
   int burst_left;
   int burst_max;
   int gap_max;
   int stall_pct;

   linear_interp_upsampler_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // a + floor((b - a) * p / 2^16)
   function automatic logic signed [SAMPLE_W-1:0] blend_floor(
      logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b, int unsigned p);
      longint prod;
      longint sum;
      prod = (longint'(b) - longint'(a)) * longint'(p);
      sum  = longint'(a) + (prod >>> 16);
      return sum[SAMPLE_W-1:0];
   endfunction

   // Work out the output frames caused by one accepted source frame
   function automatic void interpolate_frame(req_type f);
      int unsigned eff_step;
      int          n;
      rsp_type     r;
      eff_step = (step_q < STEP_MIN) ? STEP_MIN : step_q;
      if (!primed_q) begin
         // first frame only primes the stored frame
         prev_left_q  = f.left_sample;
         prev_right_q = f.right_sample;
         phase_q      = 0;
         primed_q     = 1'b1;
         return;
      end
      n = 0;
      while (phase_q < PHASE_ONE && n < MAX_RUN) begin
         r.left_out  = blend_floor(prev_left_q, f.left_sample, phase_q);
         r.right_out = blend_floor(prev_right_q, f.right_sample, phase_q);
         r.run_last  = (phase_q + eff_step >= PHASE_ONE) || (n == MAX_RUN - 1);
         expected_frames.push_back(r);
         n++;
         phase_q += eff_step;
      end
      phase_q      = (phase_q - PHASE_ONE) & 32'hFFFF;
      prev_left_q  = f.left_sample;
      prev_right_q = f.right_sample;
   endfunction

   // Output checker: each accepted frame against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("ERROR: unexpected output frame L=%0d R=%0d last=%0b",
                        rsp_payload.left_out, rsp_payload.right_out,
                        rsp_payload.run_last);
         end else begin
            want = expected_frames.pop_front();
            results_checked++;
            if (rsp_payload.left_out !== want.left_out ||
                rsp_payload.right_out !== want.right_out ||
                rsp_payload.run_last !== want.run_last) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("ERROR: output %0d exp L=%0d R=%0d last=%0b got L=%0d R=%0d last=%0b",
                           results_checked, want.left_out, want.right_out,
                           want.run_last, rsp_payload.left_out,
                           rsp_payload.right_out, rsp_payload.run_last);
            end
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL linear_interp_upsampler_core");
      $finish;
   end

   // Send one source frame request, with bursty gaps in front of it
   task automatic send_frame(req_type f);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      interpolate_frame(f);
      last_frame = f;
      frames_sent++;
   endtask

   task automatic send_pair(int l, int r);
      req_type f;
      f.left_sample  = l[SAMPLE_W-1:0];
      f.right_sample = r[SAMPLE_W-1:0];
      send_frame(f);
   endtask

   // Hold off the sender until every expected frame is out and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_step(logic [PHASE_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      step_q = v;
      steps_written++;
   endtask

   function automatic req_type random_frame();
      req_type f;
      case ($urandom_range(0, 9))
         0: begin
            // full-scale corners
            f.left_sample  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            f.right_sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         end
         1, 2: begin
            // small slope from the previous frame
            f.left_sample  = last_frame.left_sample + 16'($urandom_range(0, 64)) - 16'd32;
            f.right_sample = last_frame.right_sample + 16'($urandom_range(0, 64)) - 16'd32;
         end
         default: begin
            f = $urandom();
         end
      endcase
      return f;
   endfunction

   // Priming frame, then full-swing slopes at the reset step of 2x
   task automatic test_prime_and_reset_step();
      send_pair(32767, -32768);
      send_pair(-32768, 32767);
      send_pair(32767, -32768);
      send_pair(0, 0);
      send_pair(-1, 1);
      send_pair(1, -1);
   endtask

   // Step register at and below its floor, at the top and odd values
   task automatic test_step_limits();
      stall_pct = 30;
      write_step(16'd0);
      send_pair(-32768, 32767);
      send_pair(32767, -32768);
      send_pair(-32768, -32768);
      write_step(16'd8191);
      send_pair(32767, 0);
      send_pair(-1, -32768);
      write_step(STEP_MIN);
      send_pair(12345, -12345);
      send_pair(-32768, 32767);
      write_step(16'hFFFF);
      send_pair(32767, 32767);
      send_pair(-32768, -32768);
      send_pair(100, -100);
      send_pair(-100, 100);
      write_step(16'd32769);
      send_pair(32767, -32768);
      send_pair(-32768, 32767);
      write_step(16'd1);
      send_pair(0, -1);
      send_pair(-32768, 32767);
   endtask

   // Random content under a series of steps, gap patterns and stall levels
   task automatic test_random_streams();
      int stall_mix[5] = '{0, 25, 50, 75, 10};
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       write_step(16'($urandom_range(0, 8191)));
            4:       write_step(16'($urandom()));
            default: write_step(16'($urandom_range(8192, 65535)));
         endcase
         stall_pct = stall_mix[ph];
         gap_max   = (ph == 0) ? 0 : $urandom_range(1, 6);
         burst_max = $urandom_range(1, 12);
         for (int k = 0; k < 78; k++) begin
            // sender holds off mid-stream until the output side has caught up
            if (ph == 2 && k == 39)
               drain();
            send_frame(random_frame());
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      prev_left_q  = '0;
      prev_right_q = '0;
      phase_q      = 0;
      primed_q     = 1'b0;
      step_q       = STEP_RESET;
      last_frame   = '0;
      mismatches   = 0;
      results_checked = 0;
      frames_sent  = 0;
      steps_written = 0;
      burst_left   = 0;
      burst_max    = 4;
      gap_max      = 2;
      stall_pct    = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_prime_and_reset_step();
      test_step_limits();
      test_random_streams();

      drain();
      $display("Run covered %0d source frames and %0d output frames over %0d step settings,",
               frames_sent, results_checked, steps_written + 1);
      $display("with bursty requests, receiver stalls and a mid-stream drain.");
      if (mismatches == 0) begin
         $display("PASS linear_interp_upsampler_core");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL linear_interp_upsampler_core");
      end
      $finish;
   end

endmodule
